/* src/pnt_pkg.sv */
`default_nettype none
package pnt_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIVIDE,
    ST_ADD_D,
    ST_ADD_Q
  } pnt_state_t;

  localparam int unsigned FIRST_DIVISOR = 2;
  localparam int unsigned FIRST_SUM     = 1;

endpackage
`default_nettype wire

/* src/pnt_divider.sv */
`default_nettype none
module pnt_divider #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DW    = 18
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             go,
  input  wire logic [WIDTH-1:0] dividend,
  input  wire logic [DW-1:0]    divisor,
  output logic                  done,
  output logic [WIDTH-1:0]      quotient,
  output logic [DW-1:0]         remainder
);

  localparam int unsigned CW = $clog2(WIDTH);

  logic          active;
  logic [CW-1:0] count;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  always_comb begin
    trial = {remainder, quotient[WIDTH-1]};
    diff  = trial - {1'b0, divisor};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      count  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active <= 1'b1;
        count  <= '0;
      end else if (active) begin
        count <= count + CW'(1);
        if (count == CW'(WIDTH - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  // one restoring step per cycle
  always_ff @(posedge clk) begin
    if (go) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (active) begin
      quotient  <= {quotient[WIDTH-2:0], fits};
      remainder <= fits ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

endmodule
`default_nettype wire

/* src/perfect_number_test.sv */
// Perfect number test by trial division with one shared bit-serial divider.
// Trial divisors: 2 up to floor(sqrt(number)), fewer on early exit. Below two,
// the word is rejected from idle without dividing, with its result in the next cycle.
// One word at a time; the next word is accepted in the result cycle.
// Reset: synchronous, active high; returns to idle with no result pending.
`default_nettype none
module perfect_number_test #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [WIDTH-1:0] number,
  output logic                  done,
  output logic                  is_perfect
);
  import pnt_pkg::*;

  localparam int unsigned DW  = (WIDTH + 1) / 2 + 1;
  localparam int unsigned SQW = 2 * DW;
  localparam int unsigned SW  = WIDTH + 2;

  pnt_state_t       state, state_next;
  logic [WIDTH-1:0] n, n_next;
  logic [DW-1:0]    d, d_next;
  logic [SQW-1:0]   sq, sq_next;
  logic [SW-1:0]    sum, sum_next;
  logic             done_next, result_next;
  logic             div_go, div_done;
  logic [WIDTH-1:0] div_q;
  logic [DW-1:0]    div_r;
  logic             sum_over, sq_over;

  pnt_divider #(.WIDTH(WIDTH), .DW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (n),
    .divisor   (d),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign busy = (state != ST_IDLE);

  always_comb begin
    sum_over = sum > {2'b00, n};
    sq_over  = sq > {{(SQW-WIDTH){1'b0}}, n};
  end

  always_comb begin
    state_next  = state;
    n_next      = n;
    d_next      = d;
    sq_next     = sq;
    sum_next    = sum;
    done_next   = 1'b0;
    result_next = is_perfect;
    div_go      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          n_next   = number;
          d_next   = DW'(FIRST_DIVISOR);
          sq_next  = SQW'(FIRST_DIVISOR * FIRST_DIVISOR);
          sum_next = SW'(FIRST_SUM);
          if (number < WIDTH'(FIRST_DIVISOR)) begin
            done_next   = 1'b1;
            result_next = 1'b0;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (sum_over || sq_over) begin
          done_next   = 1'b1;
          result_next = (sum == {2'b00, n});
          state_next  = ST_IDLE;
        end else begin
          div_go     = 1'b1;
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_done) begin
          if (div_r == '0) begin
            state_next = ST_ADD_D;
          end else begin
            d_next     = d + DW'(1);
            sq_next    = sq + {{(SQW-DW-1){1'b0}}, d, 1'b1};
            state_next = ST_CHECK;
          end
        end
      end
      ST_ADD_D: begin
        sum_next   = sum + {{(SW-DW){1'b0}}, d};
        state_next = ST_ADD_Q;
      end
      ST_ADD_Q: begin
        if (div_q != {{(WIDTH-DW){1'b0}}, d}) begin
          sum_next = sum + {2'b00, div_q};
        end
        d_next     = d + DW'(1);
        sq_next    = sq + {{(SQW-DW-1){1'b0}}, d, 1'b1};
        state_next = ST_CHECK;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    n          <= n_next;
    d          <= d_next;
    sq         <= sq_next;
    sum        <= sum_next;
    is_perfect <= result_next;
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_small_number: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (number < WIDTH'(FIRST_DIVISOR))) |=> (done && !is_perfect))
    else $error("number below two not rejected at once");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("divider finished outside the divide state");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (number >= WIDTH'(FIRST_DIVISOR))) |=> (busy && !done))
    else $error("accepted word did not start a test");
`endif

endmodule
`default_nettype wire
